// ----- design/utd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utd_pkg: shared types and constants for the UTF-8 to UTF-16 decoder
// Word types for both channels, the result bundle between the decode core
// and the output buffer, and the byte and code unit constants.
// ----------------------------------------------------------------------------
package utd_pkg;

  // input word: one UTF-8 byte with string framing flags
  typedef struct packed {
    logic [7:0] data_byte;
    logic       string_start;
    logic       string_end;
  } in_word_t;

  // output word: one UTF-16 code unit
  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_last;
  } out_word_t;

  // results of one decoded byte, handed to the output buffer
  typedef struct packed {
    logic [1:0] cnt;
    out_word_t  unit0;
    out_word_t  unit1;
  } res_t;

  // byte order mark bytes
  localparam logic [7:0] BOM_B0 = 8'hEF;
  localparam logic [7:0] BOM_B1 = 8'hBB;
  localparam logic [7:0] BOM_B2 = 8'hBF;

  // lead byte thresholds
  localparam logic [7:0] LEAD_ASCII_LIM = 8'h80;
  localparam logic [7:0] LEAD_4B        = 8'hF0;
  localparam logic [7:0] LEAD_3B        = 8'hE0;
  localparam logic [7:0] LEAD_2B        = 8'hC0;

  // payload masks
  localparam logic [7:0] MASK_4B   = 8'h07;
  localparam logic [7:0] MASK_3B   = 8'h0F;
  localparam logic [7:0] MASK_2B   = 8'h1F;
  localparam logic [7:0] MASK_CONT = 8'h3F;

  // surrogate construction
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [15:0] SURR_HI   = 16'hD800;
  localparam logic [15:0] SURR_LO   = 16'hDC00;
  localparam logic [9:0]  SURR_MASK = 10'h3FF;

  // sequence sizes (continuation bytes after the lead)
  localparam logic [1:0] SEQ_NONE = 2'd0;
  localparam logic [1:0] SEQ_2B   = 2'd1;
  localparam logic [1:0] SEQ_3B   = 2'd2;
  localparam logic [1:0] SEQ_4B   = 2'd3;

  // string position saturation
  localparam logic [1:0] POS_MAX = 2'd3;

endpackage

// ----- design/utd_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utd_core: decode state and per-byte decode logic
// Holds the sequence accumulator and byte order mark tracking, decodes the
// registered input byte and produces zero, one or two code units.
// ----------------------------------------------------------------------------
module utd_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            item_vld,
  input  utd_pkg::in_word_t item,
  input  logic            can_load,
  output logic            advance,
  output logic            load,
  output utd_pkg::res_t   res
);

  logic [1:0]  pend_r, pend_nxt;
  logic [20:0] pval_r, pval_nxt;
  logic [1:0]  size_r, size_nxt;
  logic [1:0]  pos_r,  pos_nxt;
  logic        mark_r, mark_nxt;

  // decode one byte against the current state
  always_comb begin
    logic [7:0]  b;
    logic [1:0]  pend, size, pos, pend_dec;
    logic [20:0] pval, cont, cp, v;
    logic        mark;

    b    = item.data_byte;
    // string start discards any partial state first
    pend = item.string_start ? 2'd0  : pend_r;
    pval = item.string_start ? 21'd0 : pval_r;
    size = item.string_start ? utd_pkg::SEQ_NONE : size_r;
    pos  = item.string_start ? 2'd0  : pos_r;
    mark = item.string_start ? 1'b0  : mark_r;

    res      = '0;
    pend_nxt = pend;
    pval_nxt = pval;
    size_nxt = size;
    pend_dec = pend - 2'd1;
    cont     = 21'd0;
    cp       = 21'd0;
    v        = 21'd0;

    // byte order mark tracking over the first three bytes
    unique case (pos)
      2'd0:    mark_nxt = (b == utd_pkg::BOM_B0);
      2'd1:    mark_nxt = mark && (b == utd_pkg::BOM_B1);
      2'd2:    mark_nxt = mark && (b == utd_pkg::BOM_B2);
      default: mark_nxt = 1'b0;
    endcase
    pos_nxt = (pos < utd_pkg::POS_MAX) ? pos + 2'd1 : utd_pkg::POS_MAX;

    if (pend == 2'd0) begin
      // lead byte
      priority if (b < utd_pkg::LEAD_ASCII_LIM) begin
        res.cnt             = 2'd1;
        res.unit0.code_unit = {8'h00, b};
        res.unit0.run_last  = 1'b1;
      end else if (b >= utd_pkg::LEAD_4B) begin
        pval_nxt = {b[2:0] & utd_pkg::MASK_4B[2:0], 18'd0};
        pend_nxt = 2'd3;
        size_nxt = utd_pkg::SEQ_4B;
      end else if (b >= utd_pkg::LEAD_3B) begin
        pval_nxt = {5'd0, b[3:0] & utd_pkg::MASK_3B[3:0], 12'd0};
        pend_nxt = 2'd2;
        size_nxt = utd_pkg::SEQ_3B;
      end else if (b >= utd_pkg::LEAD_2B) begin
        pval_nxt = {10'd0, b[4:0] & utd_pkg::MASK_2B[4:0], 6'd0};
        pend_nxt = 2'd1;
        size_nxt = utd_pkg::SEQ_2B;
      end else begin
        // stray continuation byte: nothing
      end
    end else begin
      // continuation byte: six payload bits into place
      unique case (pend_dec)
        2'd2:    cont = {3'd0, b[5:0] & utd_pkg::MASK_CONT[5:0], 12'd0};
        2'd1:    cont = {9'd0, b[5:0] & utd_pkg::MASK_CONT[5:0], 6'd0};
        2'd0:    cont = {15'd0, b[5:0] & utd_pkg::MASK_CONT[5:0]};
        default: cont = {b[2:0], 18'd0};
      endcase
      pend_nxt = pend_dec;
      pval_nxt = pval | cont;
      if (pend_dec == 2'd0) begin
        cp = pval | cont;
        v  = cp - utd_pkg::SUPP_BASE;
        priority if (size == utd_pkg::SEQ_4B && cp >= utd_pkg::SUPP_BASE) begin
          res.cnt             = 2'd2;
          res.unit0.code_unit = utd_pkg::SURR_HI | {5'd0, v[20:10]};
          res.unit0.run_last  = 1'b0;
          res.unit1.code_unit = utd_pkg::SURR_LO | {6'd0, v[9:0] & utd_pkg::SURR_MASK};
          res.unit1.run_last  = 1'b1;
        end else if (size == utd_pkg::SEQ_3B && pos == 2'd2 && mark_nxt &&
                     !item.string_end) begin
          // byte order mark at string start is dropped
        end else begin
          res.cnt             = 2'd1;
          res.unit0.code_unit = cp[15:0];
          res.unit0.run_last  = 1'b1;
        end
        pval_nxt = 21'd0;
        size_nxt = utd_pkg::SEQ_NONE;
      end
    end

    // string end clears everything, including a cut-off sequence
    if (item.string_end) begin
      pend_nxt = 2'd0;
      pval_nxt = 21'd0;
      size_nxt = utd_pkg::SEQ_NONE;
      pos_nxt  = 2'd0;
      mark_nxt = 1'b0;
    end
  end

  // a byte with no result moves on regardless of the output side
  assign advance = item_vld && ((res.cnt == 2'd0) || can_load);
  assign load    = advance && (res.cnt != 2'd0);

  // decode state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 2'd0;
      pval_r <= 21'd0;
      size_r <= utd_pkg::SEQ_NONE;
      pos_r  <= 2'd0;
      mark_r <= 1'b0;
    end else if (advance) begin
      pend_r <= pend_nxt;
      pval_r <= pval_nxt;
      size_r <= size_nxt;
      pos_r  <= pos_nxt;
      mark_r <= mark_nxt;
    end
  end

endmodule

// ----- design/utd_outbuf.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// utd_outbuf: two-slot result register
// Holds the one or two code units of a byte and hands them out one word
// per cycle while out_ready is high; takes new results as soon as it empties in the same cycle.
// ----------------------------------------------------------------------------
module utd_outbuf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  utd_pkg::res_t      res,
  output logic               can_load,
  output logic               out_valid,
  input  logic               out_ready,
  output utd_pkg::out_word_t out_data
);

  logic [1:0]         cnt_r, cnt_nxt;
  utd_pkg::out_word_t slot0_r, slot0_nxt;
  utd_pkg::out_word_t slot1_r, slot1_nxt;
  logic               pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign pop       = out_valid && out_ready;
  assign can_load  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  // load replaces the buffer, pop shifts the second slot down
  always_comb begin
    cnt_nxt   = cnt_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    if (load) begin
      cnt_nxt   = res.cnt;
      slot0_nxt = res.unit0;
      slot1_nxt = res.unit1;
    end else if (pop) begin
      cnt_nxt   = cnt_r - 2'd1;
      slot0_nxt = slot1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

// ----- design/utf8_to_utf16_decoder.sv -----
`timescale 1ns / 1ps
// A byte accepted into the input register is decoded and its code units land in the result register.
// Throughput: one byte per cycle while out_ready is high; a surrogate pair holds the output for both units.
// Set by the two-slot result register, which emits one code unit per cycle while out_ready is high.
// Reset (rst_n low, synchronous) empties the input and result registers and
// clears all decode state; the first byte after reset starts a new string.
// ----------------------------------------------------------------------------
// utf8_to_utf16_decoder: UTF-8 byte stream to UTF-16 code units
// Input register, single-pass decode core and two-slot result register.
// ----------------------------------------------------------------------------
module utf8_to_utf16_decoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  utd_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output utd_pkg::out_word_t out_data
);

  logic              in_vld_r;
  utd_pkg::in_word_t in_word_r;
  logic              advance;
  logic              load;
  logic              can_load;
  utd_pkg::res_t     res;

  assign in_ready = !in_vld_r || advance;

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_word_r <= in_data;
    end
  end

  utd_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .item_vld (in_vld_r),
    .item     (in_word_r),
    .can_load (can_load),
    .advance  (advance),
    .load     (load),
    .res      (res)
  );

  utd_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
